[sv/prc_pkg.sv]
// Shared constants, types and the arctangent table for the point rotator.
`timescale 1ns / 1ps
`default_nettype none
package prc_pkg;

  // coordinate and angle fields
  localparam int CW            = 24;
  localparam int FRACTION_BITS = 8;
  localparam int ANG_FRAC      = 20;
  localparam int ANG_SHIFT     = ANG_FRAC - FRACTION_BITS;

  localparam int TABLE_LEN         = 24;
  localparam int CORDIC_STAGES_DEF = 16;

  // datapath widths
  localparam int XW = 32;       // cosine / sine, Q30
  localparam int ZW = 30;       // residual angle, 2^-20 degree
  localparam int DW = CW + 1;   // point minus center

  // modulo 360 degrees in input units, by reciprocal multiplication
  localparam int TURN        = 360 << FRACTION_BITS;
  localparam int TURN_W      = $clog2(TURN + 1);
  localparam int OFFSET      = (((1 << (CW - 1)) + TURN - 1) / TURN) * TURN;
  localparam int UW          = CW + 2;
  localparam int RECIP_SHIFT = 32;
  localparam longint unsigned RECIP = (64'd1 << RECIP_SHIFT) / TURN;
  localparam int RECIP_W     = $clog2(RECIP + 1);
  localparam int PW          = UW + RECIP_W;
  localparam int QW          = PW - RECIP_SHIFT;
  localparam int R0W         = TURN_W + 1;

  localparam logic signed [ZW-1:0] Z_D90  = ZW'(90 << ANG_FRAC);
  localparam logic signed [ZW-1:0] Z_D180 = ZW'(180 << ANG_FRAC);
  localparam logic signed [ZW-1:0] Z_D360 = ZW'(360 << ANG_FRAC);

  localparam logic signed [XW-1:0] GAIN_Q30 = XW'(652032874);

  // product and rounding
  localparam int PRW      = XW + DW;
  localparam int SW       = PRW + 1;
  localparam int ROUND_SH = 30;
  localparam int SXW      = SW - ROUND_SH;
  localparam int RXW      = SXW + 1;
  localparam logic signed [SW-1:0] ROUND_Q30 = SW'(64'sd536870912);

  localparam logic signed [RXW-1:0] SAT_MAX = RXW'((1 << (CW - 1)) - 1);
  localparam logic signed [RXW-1:0] SAT_MIN = -RXW'(1 << (CW - 1));

  typedef struct packed {
    logic                 v;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
  } cell_t;

  typedef struct packed {
    logic                 v;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
  } res_t;

  // atan(2^-i) in degrees, 2^-20 units
  function automatic logic signed [ZW-1:0] atan_deg(input int idx);
    logic signed [ZW-1:0] a;
    case (idx)
      0:  a = ZW'(47185920);
      1:  a = ZW'(27855475);
      2:  a = ZW'(14718068);
      3:  a = ZW'(7471121);
      4:  a = ZW'(3750058);
      5:  a = ZW'(1876857);
      6:  a = ZW'(938658);
      7:  a = ZW'(469357);
      8:  a = ZW'(234682);
      9:  a = ZW'(117342);
      10: a = ZW'(58671);
      11: a = ZW'(29335);
      12: a = ZW'(14668);
      13: a = ZW'(7334);
      14: a = ZW'(3667);
      15: a = ZW'(1833);
      16: a = ZW'(917);
      17: a = ZW'(458);
      18: a = ZW'(229);
      19: a = ZW'(115);
      20: a = ZW'(57);
      21: a = ZW'(29);
      22: a = ZW'(14);
      23: a = ZW'(7);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

[sv/prc_reduce.sv]
// Front end: angle reduction modulo one turn, half-turn fold, deltas.
`timescale 1ns / 1ps
`default_nettype none
module prc_reduce import prc_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic                 in_v,
  input  wire logic signed [CW-1:0] point_x,
  input  wire logic signed [CW-1:0] point_y,
  input  wire logic signed [CW-1:0] center_x,
  input  wire logic signed [CW-1:0] center_y,
  input  wire logic signed [CW-1:0] angle_deg,
  output cell_t                     dout
);

  localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

  // stage 1
  logic                 v1;
  logic [UW-1:0]        u1;
  logic [PW-1:0]        prod1;
  logic signed [DW-1:0] dx1, dy1;
  logic signed [CW-1:0] cx1, cy1;
  logic [UW-1:0]        u_next;
  logic [PW-1:0]        prod_next;

  // stage 2
  logic                 v2;
  logic [R0W-1:0]       r02;
  logic signed [DW-1:0] dx2, dy2;
  logic signed [CW-1:0] cx2, cy2;
  logic [QW-1:0]        q;
  logic [UW-1:0]        qt;
  logic [UW-1:0]        r0_full;

  // stage 3
  logic [TURN_W-1:0]    r;
  logic signed [ZW-1:0] z0, z1, z_next;
  logic                 flip;
  cell_t                d_next;

  // bias the angle nonnegative by a whole number of turns
  always_comb begin
    u_next    = {{(UW-CW){angle_deg[CW-1]}}, angle_deg} + UW'(OFFSET);
    prod_next = {{RECIP_W{1'b0}}, u_next} * {{UW{1'b0}}, RECIP_C};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u1    <= u_next;
      prod1 <= prod_next;
      dx1   <= DW'(point_x) - DW'(center_x);
      dy1   <= DW'(point_y) - DW'(center_y);
      cx1   <= center_x;
      cy1   <= center_y;
    end
  end

  // quotient estimate is exact or one short
  always_comb begin
    q       = prod1[PW-1:RECIP_SHIFT];
    qt      = UW'(q) * UW'(TURN);
    r0_full = u1 - qt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r02 <= r0_full[R0W-1:0];
      dx2 <= dx1;
      dy2 <= dy1;
      cx2 <= cx1;
      cy2 <= cy1;
    end
  end

  // correct remainder, then fold into [-90, 90] degrees
  always_comb begin
    r      = (r02 >= R0W'(TURN)) ? TURN_W'(r02 - R0W'(TURN)) : r02[TURN_W-1:0];
    z0     = ZW'(r) <<< ANG_SHIFT;
    z1     = (z0 > Z_D180) ? z0 - Z_D360 : z0;
    flip   = 1'b0;
    z_next = z1;
    if (z1 > Z_D90) begin
      z_next = z1 - Z_D180;
      flip   = 1'b1;
    end else if (z1 < -Z_D90) begin
      z_next = z1 + Z_D180;
      flip   = 1'b1;
    end
    // negate the deltas instead of cosine and sine
    d_next.v  = v2;
    d_next.x  = GAIN_Q30;
    d_next.y  = '0;
    d_next.z  = z_next;
    d_next.dx = flip ? -dx2 : dx2;
    d_next.dy = flip ? -dy2 : dy2;
    d_next.cx = cx2;
    d_next.cy = cy2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.v <= 1'b0;
    end else if (en) begin
      dout <= d_next;
    end
  end

endmodule
`default_nettype wire

[sv/prc_cell.sv]
// One CORDIC rotation cell: a single micro-rotation per clock while en is high.
`timescale 1ns / 1ps
`default_nettype none
module prc_cell import prc_pkg::*; #(
  parameter int STAGE = 0
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  en,
  input  wire cell_t din,
  output cell_t      dout
);

  logic signed [XW-1:0] xs, ys;
  logic signed [ZW-1:0] a;
  cell_t                d_next;

  always_comb begin
    xs     = $signed(din.x) >>> STAGE;
    ys     = $signed(din.y) >>> STAGE;
    a      = atan_deg(STAGE);
    d_next = din;
    if (!din.z[ZW-1]) begin
      d_next.x = din.x - ys;
      d_next.y = din.y + xs;
      d_next.z = din.z - a;
    end else begin
      d_next.x = din.x + ys;
      d_next.y = din.y - xs;
      d_next.z = din.z + a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.v <= 1'b0;
    end else if (en) begin
      dout <= d_next;
    end
  end

endmodule
`default_nettype wire

[sv/prc_combine.sv]
// Back end: rotation products, rounding, center add and saturation.
`timescale 1ns / 1ps
`default_nettype none
module prc_combine import prc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  en,
  input  wire cell_t din,
  output res_t       res
);

  // stage A: products
  logic                  va;
  logic signed [PRW-1:0] p_xdx, p_ydy, p_ydx, p_xdy;
  logic signed [CW-1:0]  cxa, cya;

  // stage B: rounded sums
  logic                  vb;
  logic signed [SXW-1:0] sx, sy;
  logic signed [CW-1:0]  cxb, cyb;
  logic signed [SW-1:0]  sum_x, sum_y;
  logic signed [RXW-1:0] rx, ry;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else if (en) begin
      va <= din.v;
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_xdx <= PRW'($signed(din.x)) * PRW'($signed(din.dx));
      p_ydy <= PRW'($signed(din.y)) * PRW'($signed(din.dy));
      p_ydx <= PRW'($signed(din.y)) * PRW'($signed(din.dx));
      p_xdy <= PRW'($signed(din.x)) * PRW'($signed(din.dy));
      cxa   <= din.cx;
      cya   <= din.cy;
    end
  end

  // round half up, floor shift
  always_comb begin
    sum_x = SW'(p_xdx) - SW'(p_ydy) + ROUND_Q30;
    sum_y = SW'(p_ydx) + SW'(p_xdy) + ROUND_Q30;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx  <= sum_x[SW-1:ROUND_SH];
      sy  <= sum_y[SW-1:ROUND_SH];
      cxb <= cxa;
      cyb <= cya;
    end
  end

  always_comb begin
    rx    = RXW'(sx) + RXW'(cxb);
    ry    = RXW'(sy) + RXW'(cyb);
    res.v = vb;
    if (rx > SAT_MAX) begin
      res.x = SAT_MAX[CW-1:0];
    end else if (rx < SAT_MIN) begin
      res.x = SAT_MIN[CW-1:0];
    end else begin
      res.x = rx[CW-1:0];
    end
    if (ry > SAT_MAX) begin
      res.y = SAT_MAX[CW-1:0];
    end else if (ry < SAT_MIN) begin
      res.y = SAT_MIN[CW-1:0];
    end else begin
      res.y = ry[CW-1:0];
    end
  end

endmodule
`default_nettype wire

[sv/point_rotation_about_center_top.sv]
// Top level of the pipelined CORDIC point rotator.
`timescale 1ns / 1ps
`default_nettype none
// Rotates a point about a center by an angle in 1/256 degree, counter-clockwise in a
// y-up frame, with 8 fraction bits on every coordinate; results saturate to 24 bits.
// The angle is reduced modulo 360 degrees and cosine and sine come from a chain of
// CORDIC_STAGES rotation cells, one micro-rotation per cell. One transaction is
// accepted every clock while in_stall is low; the path from input to output runs
// through three reduction stages, the cell chain, two multiply/round stages and the
// output register. A one-entry skid buffer behind the output register lets the
// pipeline take one more transaction while a result waits; in_stall rises only
// when that buffer is occupied.
module point_rotation_about_center_top import prc_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic signed [CW-1:0] point_x,
  input  wire logic signed [CW-1:0] point_y,
  input  wire logic signed [CW-1:0] center_x,
  input  wire logic signed [CW-1:0] center_y,
  input  wire logic signed [CW-1:0] angle_deg,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic signed [CW-1:0]      rotated_x,
  output logic signed [CW-1:0]      rotated_y
);

  cell_t chain [CORDIC_STAGES+1];
  res_t  res;
  res_t  skid;
  logic  en;

  assign en       = !skid.v;
  assign in_stall = skid.v;

  prc_reduce u_reduce (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_v      (in_valid),
    .point_x   (point_x),
    .point_y   (point_y),
    .center_x  (center_x),
    .center_y  (center_y),
    .angle_deg (angle_deg),
    .dout      (chain[0])
  );

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    prc_cell #(
      .STAGE (i)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (chain[i]),
      .dout (chain[i+1])
    );
  end

  prc_combine u_combine (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .din (chain[CORDIC_STAGES]),
    .res (res)
  );

  // output register with skid: drain the skid first, park a result when blocked
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid.v    <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid.v) begin
        out_valid <= 1'b1;
        rotated_x <= skid.x;
        rotated_y <= skid.y;
        skid.v    <= 1'b0;
      end else begin
        out_valid <= res.v;
        rotated_x <= res.x;
        rotated_y <= res.y;
      end
    end else if (!skid.v && res.v) begin
      skid <= res;
    end
  end

  a_skid_needs_out : assert property (@(posedge clk) disable iff (rst)
    skid.v |-> out_valid)
    else $error("skid buffer holds a result while the output register is empty");

  a_skid_fill : assert property (@(posedge clk) disable iff (rst)
    $rose(skid.v) |-> $past(out_valid && out_stall))
    else $error("skid buffer filled while the output was free");

  a_skid_drain : assert property (@(posedge clk) disable iff (rst)
    (skid.v && !out_stall) |=> (out_valid && !skid.v))
    else $error("skid buffer not drained into the output register");

endmodule
`default_nettype wire
